@@ hdl/bcdac_pkg.sv @@
// Package for the BCD alarm clock core: time types, event and register codes,
// reset values and the BCD hour and minute step functions.
// No dependencies.
`default_nettype none

package bcdac_pkg;

  // Hour and minute of one time, BCD digits.
  typedef struct packed {
    logic [1:0] ht;
    logic [3:0] ho;
    logic [2:0] mt;
    logic [3:0] mo;
  } hm_t;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_HOUR   = 2'd1,
    MODE_MINUTE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  localparam logic [1:0] SEL_CLOCK  = 2'd0;
  localparam logic [1:0] SEL_ALARM1 = 2'd1;
  localparam logic [1:0] SEL_ALARM2 = 2'd2;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLE         = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM1_ENABLE      = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM2_ENABLE      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIME_ENABLE       = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_BEEP_SECONDS = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIME_BEEP_SECONDS = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BEEP_HALF_TICKS    = 8'd7;

  localparam logic [3:0] RST_ALARM_BEEP_SECONDS = 4'd8;
  localparam logic [3:0] RST_CHIME_BEEP_SECONDS = 4'd3;
  localparam logic [7:0] RST_TICKS_PER_SECOND   = 8'd20;
  localparam logic [6:0] RST_BEEP_HALF_TICKS    = 7'd10;

  localparam hm_t RST_CLOCK  = '{ht: 2'd1, ho: 4'd2, mt: 3'd5, mo: 4'd9};
  localparam hm_t RST_ALARM1 = '{ht: 2'd1, ho: 4'd3, mt: 3'd0, mo: 4'd1};
  localparam hm_t RST_ALARM2 = '{ht: 2'd1, ho: 4'd3, mt: 3'd0, mo: 4'd2};

  // Hour +1, 23 wraps to 00.
  function automatic hm_t hour_step(hm_t t);
    hm_t r;
    r = t;
    r.ho = t.ho + 4'd1;
    if (t.ht >= 2'd2 && r.ho >= 4'd4) begin
      r.ht = 2'd0;
      r.ho = 4'd0;
    end else if (r.ho >= 4'd10) begin
      r.ho = 4'd0;
      r.ht = t.ht + 2'd1;
    end
    return r;
  endfunction

  // Minute +1, 59 wraps to 00, hour untouched.
  function automatic hm_t minute_step(hm_t t);
    hm_t r;
    r = t;
    r.mo = t.mo + 4'd1;
    if (r.mo >= 4'd10) begin
      r.mo = 4'd0;
      if (t.mt >= 3'd5) begin
        r.mt = 3'd0;
      end else begin
        r.mt = t.mt + 3'd1;
      end
    end
    return r;
  endfunction

  function automatic logic minute_wraps(hm_t t);
    return (t.mo >= 4'd9) && (t.mt >= 3'd5);
  endfunction

  function automatic logic hm_equal(hm_t a, hm_t b);
    return a == b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/bcd_alarm_clock_core.sv @@
// BCD alarm clock core: clock and two alarm times, second counting, alarm and
// hourly chime beeper, all updated in one pass per item. Uses bcdac_pkg.
//
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   s_tuser: mode; s_tdata: clock_select
// m_*      out  m_tvalid / m_tready   m_tdata: clock digits and beeper flags
// cfg_*    in   cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One item per cycle unless the output stalls: next state and result are computed
// in one pass from the state registers and the item, and land in the state and
// output registers. The output register frees up the input side: a new item is
// taken while the last result is taken, or at any time while the output register
// is empty. Reset (rst, synchronous) restores the clock to 12:59:00 and the
// register defaults; the block takes items as soon as reset is released.
`default_nettype none

module bcd_alarm_clock_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [1:0] clock_select, [7:2] zero
  input  wire logic [1:0]  s_tuser,   // [1:0] mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [1:0] hour_tens, [5:2] hour_ones,
                                      // [8:6] minute_tens, [12:9] minute_ones,
                                      // [15:13] second_tens, [19:16] second_ones,
                                      // [20] buzzer_on, [21] second_dot,
                                      // [22] beep_active, [23] zero
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [bcdac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bcdac_pkg::CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic       run_enable;
  logic       alarm1_enable;
  logic       alarm2_enable;
  logic       chime_enable;
  logic [3:0] alarm_beep_seconds;
  logic [3:0] chime_beep_seconds;
  logic [7:0] ticks_per_second;
  logic [6:0] beep_half_ticks;

  // state
  bcdac_pkg::hm_t clock_time, alarm1_time, alarm2_time;
  logic [2:0] sec_tens;
  logic [3:0] sec_ones;
  logic [7:0] subtick_count;
  logic [3:0] beep_seconds_left;
  logic [6:0] beep_on_count;
  logic [6:0] beep_off_count;
  logic       beep_second_started;
  logic       alarm1_fired;
  logic       alarm2_fired;
  logic       dot_lit;

  bcdac_pkg::hm_t clock_time_next, alarm1_time_next, alarm2_time_next;
  logic [2:0] sec_tens_next;
  logic [3:0] sec_ones_next;
  logic [7:0] subtick_count_next;
  logic [3:0] beep_seconds_left_next;
  logic [6:0] beep_on_count_next;
  logic [6:0] beep_off_count_next;
  logic       beep_second_started_next;
  logic       alarm1_fired_next;
  logic       alarm2_fired_next;
  logic       dot_lit_next;

  bcdac_pkg::mode_t mode;
  logic [1:0] clock_select;
  logic       in_accept;
  logic       match1, match2;
  logic       chime_hour;
  logic [6:0] half;

  assign mode         = bcdac_pkg::mode_t'(s_tuser);
  assign clock_select = s_tdata[1:0];
  assign s_tready     = !m_tvalid || m_tready;
  assign in_accept    = s_tvalid && s_tready;
  assign cfg_ready    = 1'b1;
  assign half         = (beep_half_ticks == 7'd0) ? 7'd1 : beep_half_ticks;

  always_comb begin
    clock_time_next          = clock_time;
    alarm1_time_next         = alarm1_time;
    alarm2_time_next         = alarm2_time;
    sec_tens_next            = sec_tens;
    sec_ones_next            = sec_ones;
    subtick_count_next       = subtick_count;
    beep_seconds_left_next   = beep_seconds_left;
    beep_on_count_next       = beep_on_count;
    beep_off_count_next      = beep_off_count;
    beep_second_started_next = beep_second_started;
    dot_lit_next             = dot_lit;
    chime_hour               = 1'b0;

    case (mode)
      bcdac_pkg::MODE_TICK: begin
        if (subtick_count <= 8'd1) begin
          subtick_count_next = ticks_per_second;
          if (run_enable) begin
            dot_lit_next = 1'b1;
            if (sec_ones < 4'd9) begin
              sec_ones_next = sec_ones + 4'd1;
            end else begin
              sec_ones_next = 4'd0;
              if (sec_tens < 3'd5) begin
                sec_tens_next = sec_tens + 3'd1;
              end else begin
                sec_tens_next   = 3'd0;
                clock_time_next = bcdac_pkg::minute_step(clock_time);
                if (bcdac_pkg::minute_wraps(clock_time)) begin
                  clock_time_next = bcdac_pkg::hour_step(clock_time_next);
                  // new hour 09 through 20
                  chime_hour = (clock_time_next.ht == 2'd0 && clock_time_next.ho == 4'd9)
                            || (clock_time_next.ht == 2'd1)
                            || (clock_time_next.ht == 2'd2 && clock_time_next.ho == 4'd0);
                end
              end
            end
          end
        end else begin
          subtick_count_next = subtick_count - 8'd1;
          if (subtick_count_next == {1'b0, ticks_per_second[7:1]}) begin
            dot_lit_next = 1'b0;
          end
        end
        if (chime_hour && chime_enable && beep_seconds_left < chime_beep_seconds) begin
          beep_seconds_left_next = chime_beep_seconds;
        end
      end
      bcdac_pkg::MODE_HOUR: begin
        case (clock_select)
          bcdac_pkg::SEL_CLOCK:  clock_time_next  = bcdac_pkg::hour_step(clock_time);
          bcdac_pkg::SEL_ALARM1: alarm1_time_next = bcdac_pkg::hour_step(alarm1_time);
          bcdac_pkg::SEL_ALARM2: alarm2_time_next = bcdac_pkg::hour_step(alarm2_time);
          default: ;
        endcase
      end
      bcdac_pkg::MODE_MINUTE: begin
        case (clock_select)
          bcdac_pkg::SEL_CLOCK:  clock_time_next  = bcdac_pkg::minute_step(clock_time);
          bcdac_pkg::SEL_ALARM1: alarm1_time_next = bcdac_pkg::minute_step(alarm1_time);
          bcdac_pkg::SEL_ALARM2: alarm2_time_next = bcdac_pkg::minute_step(alarm2_time);
          default: ;
        endcase
      end
      default: begin
        sec_tens_next = 3'd0;
        sec_ones_next = 4'd0;
      end
    endcase

    // alarm check on the updated times, every item
    match1            = bcdac_pkg::hm_equal(clock_time_next, alarm1_time_next);
    match2            = bcdac_pkg::hm_equal(clock_time_next, alarm2_time_next);
    alarm1_fired_next = alarm1_fired;
    alarm2_fired_next = alarm2_fired;
    if (!match1) begin
      alarm1_fired_next = 1'b0;
    end else if (alarm1_enable && !alarm1_fired) begin
      alarm1_fired_next      = 1'b1;
      beep_seconds_left_next = alarm_beep_seconds;
    end
    if (!match2) begin
      alarm2_fired_next = 1'b0;
    end else if (alarm2_enable && !alarm2_fired) begin
      alarm2_fired_next      = 1'b1;
      beep_seconds_left_next = alarm_beep_seconds;
    end

    // beeper advances on ticks only
    if (mode == bcdac_pkg::MODE_TICK) begin
      if (beep_on_count != 7'd0) begin
        beep_on_count_next = beep_on_count - 7'd1;
        if (beep_on_count_next == 7'd0) begin
          beep_off_count_next = half;
        end
      end else if (beep_off_count != 7'd0) begin
        beep_off_count_next = beep_off_count - 7'd1;
        if (beep_off_count_next == 7'd0) begin
          beep_second_started_next = 1'b0;
          if (beep_seconds_left_next != 4'd0) begin
            beep_seconds_left_next = beep_seconds_left_next - 4'd1;
          end
        end
      end
      if (beep_seconds_left_next != 4'd0 && !beep_second_started_next) begin
        beep_second_started_next = 1'b1;
        beep_on_count_next       = half;
        beep_off_count_next      = 7'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable         <= 1'b1;
      alarm1_enable      <= 1'b1;
      alarm2_enable      <= 1'b1;
      chime_enable       <= 1'b1;
      alarm_beep_seconds <= bcdac_pkg::RST_ALARM_BEEP_SECONDS;
      chime_beep_seconds <= bcdac_pkg::RST_CHIME_BEEP_SECONDS;
      ticks_per_second   <= bcdac_pkg::RST_TICKS_PER_SECOND;
      beep_half_ticks    <= bcdac_pkg::RST_BEEP_HALF_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bcdac_pkg::CFG_RUN_ENABLE:         run_enable         <= cfg_data[0];
        bcdac_pkg::CFG_ALARM1_ENABLE:      alarm1_enable      <= cfg_data[0];
        bcdac_pkg::CFG_ALARM2_ENABLE:      alarm2_enable      <= cfg_data[0];
        bcdac_pkg::CFG_CHIME_ENABLE:       chime_enable       <= cfg_data[0];
        bcdac_pkg::CFG_ALARM_BEEP_SECONDS: alarm_beep_seconds <= cfg_data[3:0];
        bcdac_pkg::CFG_CHIME_BEEP_SECONDS: chime_beep_seconds <= cfg_data[3:0];
        bcdac_pkg::CFG_TICKS_PER_SECOND:   ticks_per_second   <= cfg_data[7:0];
        bcdac_pkg::CFG_BEEP_HALF_TICKS:    beep_half_ticks    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_time          <= bcdac_pkg::RST_CLOCK;
      alarm1_time         <= bcdac_pkg::RST_ALARM1;
      alarm2_time         <= bcdac_pkg::RST_ALARM2;
      sec_tens            <= 3'd0;
      sec_ones            <= 4'd0;
      subtick_count       <= bcdac_pkg::RST_TICKS_PER_SECOND;
      beep_seconds_left   <= 4'd0;
      beep_on_count       <= 7'd0;
      beep_off_count      <= 7'd0;
      beep_second_started <= 1'b0;
      alarm1_fired        <= 1'b0;
      alarm2_fired        <= 1'b0;
      dot_lit             <= 1'b0;
    end else if (in_accept) begin
      clock_time          <= clock_time_next;
      alarm1_time         <= alarm1_time_next;
      alarm2_time         <= alarm2_time_next;
      sec_tens            <= sec_tens_next;
      sec_ones            <= sec_ones_next;
      subtick_count       <= subtick_count_next;
      beep_seconds_left   <= beep_seconds_left_next;
      beep_on_count       <= beep_on_count_next;
      beep_off_count      <= beep_off_count_next;
      beep_second_started <= beep_second_started_next;
      alarm1_fired        <= alarm1_fired_next;
      alarm2_fired        <= alarm2_fired_next;
      dot_lit             <= dot_lit_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      m_tdata <= {1'b0,
                  (beep_seconds_left_next != 4'd0),
                  dot_lit_next,
                  (beep_on_count_next != 7'd0),
                  sec_ones_next, sec_tens_next,
                  clock_time_next.mo, clock_time_next.mt,
                  clock_time_next.ho, clock_time_next.ht};
    end
  end

`ifndef ASSERT_OFF
  a_beep_halves_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(beep_on_count != 7'd0 && beep_off_count != 7'd0))
    else $error("beeper on and off halves both running");

  a_beep_started_tracks_halves: assert property (@(posedge clk) disable iff (rst)
    beep_second_started == (beep_on_count != 7'd0 || beep_off_count != 7'd0))
    else $error("beep second flag out of step with its halves");

  a_clock_digits_valid: assert property (@(posedge clk) disable iff (rst)
    clock_time.ht != 2'd3 && clock_time.ho <= 4'd9 && clock_time.mt <= 3'd5
    && clock_time.mo <= 4'd9 && sec_tens <= 3'd5 && sec_ones <= 4'd9
    && !(clock_time.ht == 2'd2 && clock_time.ho > 4'd3))
    else $error("clock holds a digit out of range");

  a_adjust_keeps_subtick: assert property (@(posedge clk) disable iff (rst)
    (in_accept && mode != bcdac_pkg::MODE_TICK) |=> $stable(subtick_count))
    else $error("subsecond counter moved on an adjust or clear item");
`endif

endmodule

`default_nettype wire

@@ test/tb_bcd_alarm_clock_core.sv @@
// Testbench for bcd_alarm_clock_core: predicts clock digits and beeper flags per
// item and checks every result; random stalls on both sides, several configs.
// Depends on bcdac_pkg and the core RTL.
`default_nettype none

module tb_bcd_alarm_clock_core;

  localparam int LIMIT = 200000;
  localparam logic [1:0] SEL_UNUSED = 2'd3;

  // m_tdata layout, highest field first
  typedef struct packed {
    logic       pad;
    logic       beep_active;
    logic       second_dot;
    logic       buzzer_on;
    logic [3:0] second_ones;
    logic [2:0] second_tens;
    logic [3:0] minute_ones;
    logic [2:0] minute_tens;
    logic [3:0] hour_ones;
    logic [1:0] hour_tens;
  } clock_out_t;

  class clock_scoreboard;
    bit run_en, a1_en, a2_en, chime_en;
    bit [3:0] alarm_secs, chime_secs;
    bit [7:0] tps;
    bit [6:0] half_ticks;
    bcdac_pkg::hm_t tm [3];   // clock, alarm one, alarm two
    bit [2:0] sec_t;
    bit [3:0] sec_o;
    bit [7:0] subticks;
    bit [3:0] beep_left;
    bit [6:0] on_cnt, off_cnt;
    bit beep_busy, a1_fired, a2_fired, dot;
    clock_out_t digits_due [$];
    int errors;

    function new();
      run_en = 1'b1;
      a1_en = 1'b1;
      a2_en = 1'b1;
      chime_en = 1'b1;
      alarm_secs = bcdac_pkg::RST_ALARM_BEEP_SECONDS;
      chime_secs = bcdac_pkg::RST_CHIME_BEEP_SECONDS;
      tps = bcdac_pkg::RST_TICKS_PER_SECOND;
      half_ticks = bcdac_pkg::RST_BEEP_HALF_TICKS;
      tm[0] = bcdac_pkg::RST_CLOCK;
      tm[1] = bcdac_pkg::RST_ALARM1;
      tm[2] = bcdac_pkg::RST_ALARM2;
      sec_t = 0;
      sec_o = 0;
      subticks = bcdac_pkg::RST_TICKS_PER_SECOND;
      beep_left = 0;
      on_cnt = 0;
      off_cnt = 0;
      beep_busy = 0;
      a1_fired = 0;
      a2_fired = 0;
      dot = 0;
      errors = 0;
    endfunction

    function int hours(bcdac_pkg::hm_t t);
      return t.ht * 10 + t.ho;
    endfunction

    function int minutes(bcdac_pkg::hm_t t);
      return t.mt * 10 + t.mo;
    endfunction

    function bcdac_pkg::hm_t make_hm(int h, int m);
      bcdac_pkg::hm_t r;
      r.ht = 2'(h / 10);
      r.ho = 4'(h % 10);
      r.mt = 3'(m / 10);
      r.mo = 4'(m % 10);
      return r;
    endfunction

    function int pending();
      return digits_due.size();
    endfunction

    function void write_reg(logic [bcdac_pkg::CFG_IDX_W-1:0] idx,
                            logic [bcdac_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bcdac_pkg::CFG_RUN_ENABLE:         run_en = val[0];
        bcdac_pkg::CFG_ALARM1_ENABLE:      a1_en = val[0];
        bcdac_pkg::CFG_ALARM2_ENABLE:      a2_en = val[0];
        bcdac_pkg::CFG_CHIME_ENABLE:       chime_en = val[0];
        bcdac_pkg::CFG_ALARM_BEEP_SECONDS: alarm_secs = val[3:0];
        bcdac_pkg::CFG_CHIME_BEEP_SECONDS: chime_secs = val[3:0];
        bcdac_pkg::CFG_TICKS_PER_SECOND:   tps = val;
        bcdac_pkg::CFG_BEEP_HALF_TICKS:    half_ticks = val[6:0];
        default: ;
      endcase
    endfunction

    function void count_second();
      int h;
      if (sec_o < 9) begin
        sec_o++;
      end else begin
        sec_o = 0;
        if (sec_t < 5) begin
          sec_t++;
        end else begin
          sec_t = 0;
          if (minutes(tm[0]) < 59) begin
            tm[0] = make_hm(hours(tm[0]), minutes(tm[0]) + 1);
          end else begin
            h = (hours(tm[0]) + 1) % 24;
            tm[0] = make_hm(h, 0);
            if (chime_en && h >= 9 && h <= 20 && beep_left < chime_secs)
              beep_left = chime_secs;
          end
        end
      end
    endfunction

    function void check_alarms();
      if (tm[1] != tm[0]) begin
        a1_fired = 0;
      end else if (a1_en && !a1_fired) begin
        a1_fired = 1;
        beep_left = alarm_secs;
      end
      if (tm[2] != tm[0]) begin
        a2_fired = 0;
      end else if (a2_en && !a2_fired) begin
        a2_fired = 1;
        beep_left = alarm_secs;
      end
    endfunction

    function void beep_tick();
      bit [6:0] half;
      half = (half_ticks != 0) ? half_ticks : 7'd1;
      if (on_cnt > 0) begin
        on_cnt--;
        if (on_cnt == 0) off_cnt = half;
      end else if (off_cnt > 0) begin
        off_cnt--;
        if (off_cnt == 0) begin
          beep_busy = 0;
          if (beep_left > 0) beep_left--;
        end
      end
      if (beep_left > 0 && !beep_busy) begin
        beep_busy = 1;
        on_cnt = half;
        off_cnt = 0;
      end
    endfunction

    // advance the predicted state by one accepted item, queue its result
    function void apply_item(bcdac_pkg::mode_t md, logic [1:0] sel);
      clock_out_t r;
      if (md == bcdac_pkg::MODE_TICK) begin
        if (subticks <= 1) begin
          subticks = tps;
          if (run_en) begin
            dot = 1;
            count_second();
          end
        end else begin
          subticks--;
          if (subticks == (tps >> 1)) dot = 0;
        end
        check_alarms();
        beep_tick();
      end else begin
        if (md == bcdac_pkg::MODE_HOUR && sel <= bcdac_pkg::SEL_ALARM2)
          tm[sel] = make_hm((hours(tm[sel]) + 1) % 24, minutes(tm[sel]));
        else if (md == bcdac_pkg::MODE_MINUTE && sel <= bcdac_pkg::SEL_ALARM2)
          tm[sel] = make_hm(hours(tm[sel]), (minutes(tm[sel]) + 1) % 60);
        else if (md == bcdac_pkg::MODE_CLEAR) begin
          sec_t = 0;
          sec_o = 0;
        end
        check_alarms();
      end
      r.pad = 1'b0;
      r.beep_active = (beep_left != 0);
      r.second_dot = dot;
      r.buzzer_on = (on_cnt != 0);
      r.second_ones = sec_o;
      r.second_tens = sec_t;
      r.minute_ones = tm[0].mo;
      r.minute_tens = tm[0].mt;
      r.hour_ones = tm[0].ho;
      r.hour_tens = tm[0].ht;
      digits_due.push_back(r);
    endfunction

    function void cmp_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t %s: expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_display(clock_out_t got);
      clock_out_t want;
      if (digits_due.size() == 0) begin
        $display("%0t unexpected item: expected none, got %h", $time, got);
        errors++;
        return;
      end
      want = digits_due.pop_front();
      cmp_field("hour_tens", want.hour_tens, got.hour_tens);
      cmp_field("hour_ones", want.hour_ones, got.hour_ones);
      cmp_field("minute_tens", want.minute_tens, got.minute_tens);
      cmp_field("minute_ones", want.minute_ones, got.minute_ones);
      cmp_field("second_tens", want.second_tens, got.second_tens);
      cmp_field("second_ones", want.second_ones, got.second_ones);
      cmp_field("buzzer_on", want.buzzer_on, got.buzzer_on);
      cmp_field("second_dot", want.second_dot, got.second_dot);
      cmp_field("beep_active", want.beep_active, got.beep_active);
      cmp_field("pad", want.pad, got.pad);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [1:0] s_tuser = bcdac_pkg::MODE_TICK;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [bcdac_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [bcdac_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  clock_scoreboard sb;
  bit quiet = 1'b0;          // no idling on either side while set
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int n_sent = 0;
  int cycle_count = 0;

  bcd_alarm_clock_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_done) begin
      holds_done <= hold_requests;
      hold_left <= 300;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(0, 99) >= 6);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_display(m_tdata);
  end

  // tick run length trimmed to what is left of a phase's item count
  function automatic int budget(int n, int target);
    int left;
    left = target - n_sent;
    if (left < 1) left = 1;
    return (n < left) ? n : left;
  endfunction

  task automatic send_item(bcdac_pkg::mode_t md, logic [1:0] sel);
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= md;
    s_tdata <= {6'd0, sel};
    do @(posedge clk); while (!s_tready);
    sb.apply_item(md, sel);
    n_sent++;
  endtask

  task automatic run_ticks(int n);
    repeat (n) send_item(bcdac_pkg::MODE_TICK, 2'($urandom_range(0, 3)));
  endtask

  task automatic drain();
    @(negedge clk) s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [bcdac_pkg::CFG_IDX_W-1:0] idx, int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= bcdac_pkg::CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, bcdac_pkg::CFG_DATA_W'(val));
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic configure(int run, int a1, int a2, int ch, int asec, int csec, int tps,
                           int half);
    write_reg(bcdac_pkg::CFG_RUN_ENABLE, run);
    write_reg(bcdac_pkg::CFG_ALARM1_ENABLE, a1);
    write_reg(bcdac_pkg::CFG_ALARM2_ENABLE, a2);
    write_reg(bcdac_pkg::CFG_CHIME_ENABLE, ch);
    write_reg(bcdac_pkg::CFG_ALARM_BEEP_SECONDS, asec);
    write_reg(bcdac_pkg::CFG_CHIME_BEEP_SECONDS, csec);
    write_reg(bcdac_pkg::CFG_TICKS_PER_SECOND, tps);
    write_reg(bcdac_pkg::CFG_BEEP_HALF_TICKS, half);
  endtask

  // step one time (hour, then minute, no carry) until it shows h:m
  task automatic steer_time(logic [1:0] sel, int h, int m);
    int steps;
    steps = (h - sb.hours(sb.tm[sel]) + 24) % 24;
    repeat (steps) send_item(bcdac_pkg::MODE_HOUR, sel);
    steps = (m - sb.minutes(sb.tm[sel]) + 60) % 60;
    repeat (steps) send_item(bcdac_pkg::MODE_MINUTE, sel);
  endtask

  task automatic random_phase(int target);
    int r, ahead, dest, h, n;
    logic [1:0] sel;
    while (n_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        run_ticks($urandom_range(1, 30));
      end else if (r < 75) begin
        send_item(bcdac_pkg::mode_t'($urandom_range(1, 3)), 2'($urandom_range(0, 3)));
      end else if (r < 87) begin
        // alarm set a little ahead of the clock, then a capped run of ticks toward it
        sel = $urandom_range(0, 1) ? bcdac_pkg::SEL_ALARM2 : bcdac_pkg::SEL_ALARM1;
        ahead = $urandom_range(0, 2);
        dest = (sb.hours(sb.tm[0]) * 60 + sb.minutes(sb.tm[0]) + ahead) % 1440;
        steer_time(sel, dest / 60, dest % 60);
        n = ahead * 60 * sb.tps + 2 * sb.tps;
        run_ticks(budget(n > 250 ? 250 : n, target));
      end else if (r < 95) begin
        // clock to hh:59:00, then a capped run of ticks toward the next hour
        case ($urandom_range(0, 4))
          0: h = 8;
          1: h = 19;
          2: h = 20;
          3: h = 23;
          default: h = $urandom_range(0, 23);
        endcase
        steer_time(bcdac_pkg::SEL_CLOCK, h, 59);
        send_item(bcdac_pkg::MODE_CLEAR, 2'($urandom_range(0, 3)));
        n = 60 * sb.tps + 10;
        run_ticks(budget(n > 250 ? 250 : n, target));
      end else begin
        drain();
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: unused select, clear, each adjust, both alarms firing
    send_item(bcdac_pkg::MODE_HOUR, SEL_UNUSED);
    send_item(bcdac_pkg::MODE_MINUTE, SEL_UNUSED);
    send_item(bcdac_pkg::MODE_CLEAR, bcdac_pkg::SEL_ALARM2);
    send_item(bcdac_pkg::MODE_HOUR, bcdac_pkg::SEL_CLOCK);
    send_item(bcdac_pkg::MODE_MINUTE, bcdac_pkg::SEL_CLOCK);
    send_item(bcdac_pkg::MODE_MINUTE, bcdac_pkg::SEL_CLOCK);
    send_item(bcdac_pkg::MODE_MINUTE, bcdac_pkg::SEL_CLOCK);
    send_item(bcdac_pkg::MODE_HOUR, bcdac_pkg::SEL_ALARM1);
    send_item(bcdac_pkg::MODE_MINUTE, bcdac_pkg::SEL_ALARM2);
    run_ticks(16);
    random_phase(n_sent + 90);
    drain();

    configure(1, 1, 1, 1, 15, 15, 2, 1);
    hold_requests++;
    random_phase(n_sent + 110);
    drain();

    quiet = 1'b1;
    configure(1, 0, 0, 0, 0, 0, 255, 127);
    random_phase(n_sent + 60);
    drain();
    quiet = 1'b0;

    configure(0, 1, 0, 1, $urandom_range(0, 15), $urandom_range(0, 15),
              $urandom_range(2, 6), $urandom_range(1, 12));
    random_phase(n_sent + 80);
    drain();

    repeat (2) begin
      configure($urandom_range(0, 4) != 0, $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 1), $urandom_range(0, 15), $urandom_range(0, 15),
                $urandom_range(0, 3) == 0 ? $urandom_range(2, 255) : $urandom_range(2, 6),
                $urandom_range(0, 1) ? $urandom_range(1, 12) : $urandom_range(1, 127));
      hold_requests++;
      random_phase(n_sent + 120);
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ bcd_alarm_clock_core.f @@
hdl/bcdac_pkg.sv
hdl/bcd_alarm_clock_core.sv
test/tb_bcd_alarm_clock_core.sv
